### src/qtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qtl_pkg;

    localparam int NUM_ACTIONS = 4;
    localparam int IDX_W       = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
    localparam int CNT_W       = $clog2(NUM_ACTIONS + 1);

    localparam int PICK_W      = 16;

    localparam int VAL_W       = 32;
    localparam int MUL_A_W     = 34;
    localparam int MUL_B_W     = 18;
    localparam int ACC_W       = MUL_A_W + MUL_B_W;

    localparam int IN_DATA_W   = 144;
    localparam int OUT_DATA_W  = 88;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] ACT_SELECT = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_WRITE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THROUGHPUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BUFFER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RETRANSMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT          = 3'd5;

    localparam logic [15:0] WEIGHT_THROUGHPUT_RST = 16'd768;
    localparam logic [15:0] WEIGHT_BUFFER_RST     = 16'd128;
    localparam logic [15:0] WEIGHT_RETRANSMIT_RST = 16'd512;
    localparam logic [7:0]  BUFFER_CAP_RST        = 8'd20;
    localparam logic [15:0] LEARN_RATE_RST        = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST          = 16'd58982;

    localparam logic [15:0] RETRANS_ONE = 16'd256;
    localparam logic [16:0] LR_ONE      = 17'h10000;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } qtl_wr_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] x);
        logic signed [VAL_W-1:0] res;
        if (!x[ACC_W-1] && (|x[ACC_W-2:VAL_W-1]))
            res = {1'b0, {(VAL_W-1){1'b1}}};
        else if (x[ACC_W-1] && !(&x[ACC_W-2:VAL_W-1]))
            res = {1'b1, {(VAL_W-1){1'b0}}};
        else
            res = x[VAL_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

### src/qtl_table.sv
`timescale 1ns / 1ps
`default_nettype none

module qtl_table (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire qtl_pkg::qtl_wr_t                   wr,
    input  wire logic [qtl_pkg::IDX_W-1:0]          rd_addr,
    output logic signed [qtl_pkg::VAL_W-1:0]        rd_value
);
    import qtl_pkg::*;

    logic [VAL_W-1:0]       mem [NUM_ACTIONS];
    logic [NUM_ACTIONS-1:0] vld_reg;
    logic [VAL_W-1:0]       rd_data_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_value = rd_vld_reg ? $signed(rd_data_reg) : '0;

endmodule

`default_nettype wire

### src/q_table_epsilon_greedy_learner_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Q-value table with epsilon-greedy selection. Items arrive on the s_ stream
// (tuser = action: 0 select, 1 update, 2 write) and each gives one result on the
// m_ stream. Every item first scans the whole table through its single read port,
// one entry per cycle, to find the first largest entry (best_action). The explore
// choice, random_pick modulo NUM_ACTIONS, is taken when the item is accepted.
// An update item then runs eight steps through one shared 34x18 multiplier and
// accumulator: reward terms, discount*maxq, and the blend.
// The block takes one item at a time and a new one once the previous result is
// in the output register.
// The table reads as zero at reset; no clearing pass is needed.
module q_table_epsilon_greedy_learner_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // entry_index, tx_count, rx_count, buffer_before, buffer_after,
    // retrans_average, explore_chance, random_draw, random_pick, entry_value
    input  wire logic [qtl_pkg::IN_DATA_W-1:0]         s_tdata,
    // action
    input  wire logic [1:0]                            s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // chosen_action, explored, best_action, new_value, reward_value
    output logic [qtl_pkg::OUT_DATA_W-1:0]             m_tdata,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [qtl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [qtl_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import qtl_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_ARITH  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [2:0] STEP_LOAD    = 3'd0;
    localparam logic [2:0] STEP_DRAIN   = 3'd1;
    localparam logic [2:0] STEP_RETRANS = 3'd2;
    localparam logic [2:0] STEP_DISC    = 3'd3;
    localparam logic [2:0] STEP_INNER   = 3'd4;
    localparam logic [2:0] STEP_KEEP    = 3'd5;
    localparam logic [2:0] STEP_BLEND   = 3'd6;
    localparam logic [2:0] STEP_ROUND   = 3'd7;

    // control
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [2:0]        step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       wt_reg, wt_next;
    logic [15:0]       wb_reg, wb_next;
    logic [15:0]       wr_reg, wr_next;
    logic [7:0]        cap_reg, cap_next;
    logic [15:0]       lr_reg, lr_next;
    logic [15:0]       disc_reg, disc_next;

    // payload
    logic [1:0]                act_reg, act_next;
    logic [7:0]                idx_reg, idx_next;
    logic [7:0]                tx_reg, tx_next;
    logic [7:0]                rx_reg, rx_next;
    logic [7:0]                before_reg, before_next;
    logic [7:0]                after_reg, after_next;
    logic [15:0]               retrans_reg, retrans_next;
    logic [16:0]               eps_reg, eps_next;
    logic [15:0]               draw_reg, draw_next;
    logic signed [VAL_W-1:0]   value_reg, value_next;
    logic [IDX_W-1:0]          rem_reg, rem_next;
    logic [IDX_W-1:0]          best_reg, best_next;
    logic signed [VAL_W-1:0]   max_reg, max_next;
    logic signed [VAL_W-1:0]   q_reg, q_next;
    logic signed [ACC_W-1:0]   mul_reg, mul_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [VAL_W-1:0]   rew_reg, rew_next;
    logic signed [MUL_A_W-1:0] inner_reg, inner_next;
    logic signed [VAL_W-1:0]   new_reg, new_next;
    logic [OUT_DATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      idx_ok;
    logic [CNT_W-1:0]          scan_prev;
    logic [8:0]                tx_rx;
    logic [7:0]                diff;
    logic [7:0]                drain;
    logic [15:0]               rexcess;
    logic                      out_explored;
    logic [7:0]                out_chosen;
    logic signed [VAL_W-1:0]   out_new;
    logic signed [VAL_W-1:0]   out_rew;
    qtl_wr_t                   tbl_wr;
    logic [IDX_W-1:0]          rd_addr;
    logic signed [VAL_W-1:0]   rd_value;

    qtl_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd_value (rd_value)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign idx_ok    = ({1'b0, idx_reg} < 9'(NUM_ACTIONS));
    assign scan_prev = scan_cnt_reg - CNT_W'(1);
    assign tx_rx     = {1'b0, tx_reg} + {1'b0, rx_reg};
    assign diff      = (before_reg > after_reg) ? (before_reg - after_reg) : 8'd0;
    assign drain     = (diff > cap_reg) ? cap_reg : diff;
    assign rexcess   = (retrans_reg > RETRANS_ONE) ? (retrans_reg - RETRANS_ONE) : 16'd0;

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        wt_next       = wt_reg;
        wb_next       = wb_reg;
        wr_next       = wr_reg;
        cap_next      = cap_reg;
        lr_next       = lr_reg;
        disc_next     = disc_reg;
        act_next      = act_reg;
        idx_next      = idx_reg;
        tx_next       = tx_reg;
        rx_next       = rx_reg;
        before_next   = before_reg;
        after_next    = after_reg;
        retrans_next  = retrans_reg;
        eps_next      = eps_reg;
        draw_next     = draw_reg;
        value_next    = value_reg;
        rem_next      = rem_reg;
        best_next     = best_reg;
        max_next      = max_reg;
        q_next        = q_reg;
        acc_next      = acc_reg;
        rew_next      = rew_reg;
        inner_next    = inner_reg;
        new_next      = new_reg;
        m_tdata_next  = m_tdata_reg;
        mul_a         = '0;
        mul_b         = '0;
        tbl_wr        = '0;
        rd_addr       = '0;
        out_explored  = 1'b0;
        out_chosen    = 8'd0;
        out_new       = '0;
        out_rew       = '0;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WEIGHT_THROUGHPUT: wt_next   = cfg_wdata;
                CFG_WEIGHT_BUFFER:     wb_next   = cfg_wdata;
                CFG_WEIGHT_RETRANSMIT: wr_next   = cfg_wdata;
                CFG_BUFFER_CAP:        cap_next  = cfg_wdata[7:0];
                CFG_LEARN_RATE:        lr_next   = cfg_wdata;
                CFG_DISCOUNT:          disc_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next      = s_tuser;
                    idx_next      = s_tdata[7:0];
                    tx_next       = s_tdata[15:8];
                    rx_next       = s_tdata[23:16];
                    before_next   = s_tdata[31:24];
                    after_next    = s_tdata[39:32];
                    retrans_next  = s_tdata[55:40];
                    eps_next      = s_tdata[72:56];
                    draw_next     = s_tdata[88:73];
                    rem_next      = IDX_W'(s_tdata[104:89] % PICK_W'(NUM_ACTIONS));
                    value_next    = $signed(s_tdata[136:105]);
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg != CNT_W'(NUM_ACTIONS))
                    rd_addr = scan_cnt_reg[IDX_W-1:0];
                else if (idx_ok)
                    rd_addr = idx_reg[IDX_W-1:0];

                // read data is registered, so it arrives in the cycle after its address
                if (scan_cnt_reg == CNT_W'(1))
                begin
                    best_next = '0;
                    max_next  = rd_value;
                end
                else if (scan_cnt_reg != '0 && rd_value > max_reg)
                begin
                    best_next = scan_prev[IDX_W-1:0];
                    max_next  = rd_value;
                end

                if (scan_cnt_reg == CNT_W'(NUM_ACTIONS))
                begin
                    step_next  = STEP_LOAD;
                    state_next = (act_reg == ACT_UPDATE) ? ST_ARITH : ST_FINISH;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end
            ST_ARITH:
            begin
                step_next = step_reg + 3'd1;
                unique case (step_reg)
                    STEP_LOAD:
                    begin
                        q_next = rd_value;
                        mul_a  = $signed(MUL_A_W'(tx_rx));
                        mul_b  = $signed(MUL_B_W'(wt_reg));
                    end
                    STEP_DRAIN:
                    begin
                        acc_next = mul_reg <<< 8;
                        mul_a    = $signed(MUL_A_W'(drain));
                        mul_b    = $signed(MUL_B_W'(wb_reg));
                    end
                    STEP_RETRANS:
                    begin
                        acc_next = acc_reg - (mul_reg <<< 8);
                        mul_a    = $signed(MUL_A_W'(rexcess));
                        mul_b    = $signed(MUL_B_W'(wr_reg));
                    end
                    STEP_DISC:
                    begin
                        acc_next = acc_reg - mul_reg;
                        mul_a    = MUL_A_W'(max_reg);
                        mul_b    = $signed(MUL_B_W'(disc_reg));
                    end
                    STEP_INNER:
                    begin
                        rew_next   = sat_val(acc_reg);
                        inner_next = MUL_A_W'(sat_val(acc_reg)) + MUL_A_W'(mul_reg >>> 16);
                        mul_a      = MUL_A_W'(q_reg);
                        mul_b      = $signed(MUL_B_W'(LR_ONE - {1'b0, lr_reg}));
                    end
                    STEP_KEEP:
                    begin
                        acc_next = mul_reg;
                        mul_a    = inner_reg;
                        mul_b    = $signed(MUL_B_W'(lr_reg));
                    end
                    STEP_BLEND:
                    begin
                        acc_next = acc_reg + mul_reg;
                    end
                    STEP_ROUND:
                    begin
                        new_next   = sat_val(acc_reg >>> 16);
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    unique case (act_reg)
                        ACT_SELECT:
                        begin
                            out_explored = ({1'b0, draw_reg} < eps_reg);
                            out_chosen   = out_explored ? 8'(rem_reg) : 8'(best_reg);
                        end
                        ACT_UPDATE:
                        begin
                            out_rew = rew_reg;
                            if (idx_ok)
                            begin
                                out_new     = new_reg;
                                tbl_wr.en   = 1'b1;
                                tbl_wr.addr = idx_reg[IDX_W-1:0];
                                tbl_wr.data = new_reg;
                            end
                        end
                        ACT_WRITE:
                        begin
                            if (idx_ok)
                            begin
                                out_new     = value_reg;
                                tbl_wr.en   = 1'b1;
                                tbl_wr.addr = idx_reg[IDX_W-1:0];
                                tbl_wr.data = value_reg;
                            end
                        end
                        default: ;
                    endcase
                    m_tdata_next  = OUT_DATA_W'({out_rew, out_new, 8'(best_reg),
                                                 out_explored, out_chosen});
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
        endcase

        mul_next = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            step_reg     <= STEP_LOAD;
            m_tvalid_reg <= 1'b0;
            wt_reg       <= WEIGHT_THROUGHPUT_RST;
            wb_reg       <= WEIGHT_BUFFER_RST;
            wr_reg       <= WEIGHT_RETRANSMIT_RST;
            cap_reg      <= BUFFER_CAP_RST;
            lr_reg       <= LEARN_RATE_RST;
            disc_reg     <= DISCOUNT_RST;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            wt_reg       <= wt_next;
            wb_reg       <= wb_next;
            wr_reg       <= wr_next;
            cap_reg      <= cap_next;
            lr_reg       <= lr_next;
            disc_reg     <= disc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        idx_reg     <= idx_next;
        tx_reg      <= tx_next;
        rx_reg      <= rx_next;
        before_reg  <= before_next;
        after_reg   <= after_next;
        retrans_reg <= retrans_next;
        eps_reg     <= eps_next;
        draw_reg    <= draw_next;
        value_reg   <= value_next;
        rem_reg     <= rem_next;
        best_reg    <= best_next;
        max_reg     <= max_next;
        q_reg       <= q_next;
        mul_reg     <= mul_next;
        acc_reg     <= acc_next;
        rew_reg     <= rew_next;
        inner_reg   <= inner_next;
        new_reg     <= new_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_arith_only_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ARITH) |-> (act_reg == ACT_UPDATE))
        else $error("arithmetic sequence running for a non-update item");

    a_write_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |-> (state_reg == ST_FINISH) && m_tvalid_next)
        else $error("table written outside result hand-off");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> ({1'b0, rem_reg} < (IDX_W + 1)'(NUM_ACTIONS)))
        else $error("explore remainder out of range");

    a_chosen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[7:0]} < 9'(NUM_ACTIONS)))
        else $error("chosen action beyond table size");

    a_transfer_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (scan_cnt_reg == '0) && (state_reg == ST_SCAN))
        else $error("transfer did not start a new scan");
`endif

endmodule

`default_nettype wire

### tb/sv/q_table_epsilon_greedy_learner_top_test.sv
`timescale 1ns / 1ps

module q_table_epsilon_greedy_learner_top_test;

    import qtl_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int QUIET_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 24;
    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 205;
    localparam int MAX_PRINTED      = 40;

    // input transfer fields, lowest bits last
    typedef struct packed {
        logic [31:0] entry_value;
        logic [15:0] random_pick;
        logic [15:0] random_draw;
        logic [16:0] explore_chance;
        logic [15:0] retrans_average;
        logic [7:0]  buffer_after;
        logic [7:0]  buffer_before;
        logic [7:0]  rx_count;
        logic [7:0]  tx_count;
        logic [7:0]  entry_index;
    } item_data_t;

    // output transfer fields, lowest bits last
    typedef struct packed {
        logic [31:0] reward_value;
        logic [31:0] new_value;
        logic [7:0]  best_action;
        logic        explored;
        logic [7:0]  chosen_action;
    } result_t;

    localparam int ITEM_W   = $bits(item_data_t);
    localparam int RESULT_W = $bits(result_t);

    class learner_scoreboard;
        int      q_values[NUM_ACTIONS];
        longint  w_throughput;
        longint  w_buffer;
        longint  w_retransmit;
        longint  drain_cap;
        longint  alpha;
        longint  gamma;
        result_t expected_results[$];
        int      errors;
        int      n_checked;
        int      n_select;
        int      n_explored;
        int      n_update;
        int      n_write;
        int      n_unused;
        int      n_settings;

        function new();
            foreach (q_values[i])
                q_values[i] = 0;
            w_throughput = WEIGHT_THROUGHPUT_RST;
            w_buffer     = WEIGHT_BUFFER_RST;
            w_retransmit = WEIGHT_RETRANSMIT_RST;
            drain_cap    = BUFFER_CAP_RST;
            alpha        = LEARN_RATE_RST;
            gamma        = DISCOUNT_RST;
            errors       = 0;
            n_checked    = 0;
            n_select     = 0;
            n_explored   = 0;
            n_update     = 0;
            n_write      = 0;
            n_unused     = 0;
            n_settings   = 1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WEIGHT_THROUGHPUT: w_throughput = data;
                CFG_WEIGHT_BUFFER:     w_buffer = data;
                CFG_WEIGHT_RETRANSMIT: w_retransmit = data;
                CFG_BUFFER_CAP:        drain_cap = data[7:0];
                CFG_LEARN_RATE:        alpha = data;
                CFG_DISCOUNT:          gamma = data;
                default:               ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int best_entry();
            int b;
            b = 0;
            for (int i = 1; i < NUM_ACTIONS; i++)
                if (q_values[i] > q_values[b])
                    b = i;
            return b;
        endfunction

        function longint clamp32(longint x);
            if (x > 64'sd2147483647)
                return 64'sd2147483647;
            if (x < -64'sd2147483648)
                return -64'sd2147483648;
            return x;
        endfunction

        function longint traffic_reward(item_data_t d);
            longint drain;
            longint r;
            drain = longint'(d.buffer_before) - longint'(d.buffer_after);
            if (drain < 0)
                drain = 0;
            if (drain > drain_cap)
                drain = drain_cap;
            r = w_throughput * (longint'(d.tx_count) + longint'(d.rx_count)) * 256;
            r = r - w_buffer * drain * 256;
            if (d.retrans_average > RETRANS_ONE)
                r = r - w_retransmit * (longint'(d.retrans_average) - 256);
            return clamp32(r);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        // transfer accepted on the input side
        task accept_item(logic [1:0] act, item_data_t d);
            result_t e;
            int      best;
            longint  rew;
            longint  q;
            longint  inner;
            longint  acc;
            e = '0;
            best = best_entry();
            e.best_action = 8'(best);
            case (act)
                ACT_SELECT:
                begin
                    n_select++;
                    if (d.random_draw < d.explore_chance)
                    begin
                        e.explored = 1'b1;
                        e.chosen_action = 8'(d.random_pick % NUM_ACTIONS);
                        n_explored++;
                    end
                    else
                        e.chosen_action = 8'(best);
                end
                ACT_UPDATE:
                begin
                    n_update++;
                    rew = traffic_reward(d);
                    e.reward_value = 32'(rew);
                    if (d.entry_index < NUM_ACTIONS)
                    begin
                        q = q_values[d.entry_index];
                        inner = rew + ((gamma * longint'(q_values[best])) >>> 16);
                        acc = (65536 - alpha) * q + alpha * inner;
                        e.new_value = 32'(clamp32(acc >>> 16));
                        q_values[d.entry_index] = int'(e.new_value);
                    end
                end
                ACT_WRITE:
                begin
                    n_write++;
                    if (d.entry_index < NUM_ACTIONS)
                    begin
                        e.new_value = d.entry_value;
                        q_values[d.entry_index] = int'(d.entry_value);
                    end
                end
                default:
                    n_unused++;
            endcase
            expected_results.push_back(e);
        endtask

        // transfer accepted on the output side
        task check_result(result_t got);
            result_t e;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            e = expected_results.pop_front();
            n_checked++;
            if (got.chosen_action !== e.chosen_action)
                report($sformatf("chosen_action got %0d expected %0d",
                                 got.chosen_action, e.chosen_action));
            if (got.explored !== e.explored)
                report($sformatf("explored got %0d expected %0d", got.explored, e.explored));
            if (got.best_action !== e.best_action)
                report($sformatf("best_action got %0d expected %0d",
                                 got.best_action, e.best_action));
            if (got.new_value !== e.new_value)
                report($sformatf("new_value got %h expected %h", got.new_value, e.new_value));
            if (got.reward_value !== e.reward_value)
                report($sformatf("reward_value got %h expected %h",
                                 got.reward_value, e.reward_value));
        endtask
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_W-1:0]      s_tdata   = '0;
    logic [1:0]                s_tuser   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]     m_tdata;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

    bit                        bursts_on = 1'b1;
    int                        quiet_cycles = 0;
    learner_scoreboard         sb;

    q_table_epsilon_greedy_learner_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(result_t'(m_tdata[RESULT_W-1:0]));
            if (s_tvalid && s_tready)
                sb.accept_item(s_tuser, item_data_t'(s_tdata[ITEM_W-1:0]));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("q_table_epsilon_greedy_learner_top_test: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side backpressure
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (bursts_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic send_item(logic [1:0] act, item_data_t d);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(IN_DATA_W-ITEM_W){1'b0}}, d};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_registers(logic [15:0] wt, logic [15:0] wb, logic [15:0] wr,
                                 logic [15:0] cap, logic [15:0] lr, logic [15:0] disc);
        write_reg(CFG_WEIGHT_THROUGHPUT, wt);
        write_reg(CFG_WEIGHT_BUFFER, wb);
        write_reg(CFG_WEIGHT_RETRANSMIT, wr);
        write_reg(CFG_BUFFER_CAP, cap);
        write_reg(CFG_LEARN_RATE, lr);
        write_reg(CFG_DISCOUNT, disc);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        sb.n_settings++;
    endtask

    task automatic send_select(logic [16:0] eps, logic [15:0] draw, logic [15:0] pick);
        item_data_t d;
        d = '0;
        d.explore_chance = eps;
        d.random_draw = draw;
        d.random_pick = pick;
        send_item(ACT_SELECT, d);
    endtask

    task automatic send_update(logic [7:0] idx, logic [7:0] tx, logic [7:0] rx,
                               logic [7:0] bef, logic [7:0] aft, logic [15:0] retr);
        item_data_t d;
        d = '0;
        d.entry_index = idx;
        d.tx_count = tx;
        d.rx_count = rx;
        d.buffer_before = bef;
        d.buffer_after = aft;
        d.retrans_average = retr;
        send_item(ACT_UPDATE, d);
    endtask

    task automatic send_write(logic [7:0] idx, logic [31:0] value);
        item_data_t d;
        d = '0;
        d.entry_index = idx;
        d.entry_value = value;
        send_item(ACT_WRITE, d);
    endtask

    task automatic send_random_item();
        logic [159:0] raw;
        item_data_t   d;
        logic [1:0]   act;
        int           kind;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        d = raw[ITEM_W-1:0];
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 11) != 0)
            d.entry_index = 8'($urandom_range(0, NUM_ACTIONS - 1));
        if (kind < 35)
        begin
            act = ACT_SELECT;
            case ($urandom_range(0, 3))
                0: ;
                1: d.explore_chance = 17'($urandom_range(0, 65536));
                2: d.explore_chance = {1'b0, d.random_draw};
                default: d.explore_chance = {1'b0, d.random_draw} + 17'd1;
            endcase
        end
        else if (kind < 70)
        begin
            act = ACT_UPDATE;
            if ($urandom_range(0, 1) == 0)
                d.retrans_average = 16'($urandom_range(192, 320));
            if ($urandom_range(0, 2) == 0)
                d.buffer_after = d.buffer_before - 8'($urandom_range(0, 30));
        end
        else if (kind < 92)
        begin
            act = ACT_WRITE;
            case ($urandom_range(0, 2))
                0: ;
                1: d.entry_value = {{12{raw[159]}}, raw[159:140]};
                default:
                    case ($urandom_range(0, 4))
                        0: d.entry_value = 32'h7FFF_FFFF;
                        1: d.entry_value = 32'h8000_0000;
                        2: d.entry_value = 32'h0000_0000;
                        3: d.entry_value = 32'hFFFF_FFFF;
                        default: d.entry_value = 32'h0001_0000;
                    endcase
            endcase
        end
        else
            act = ACT_UNUSED;
        send_item(act, d);
    endtask

    initial
    begin
        logic [159:0] raw;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset settings
        send_select(17'd0, 16'd0, 16'd0);
        send_select(17'h10000, 16'hFFFF, 16'hFFFF);
        send_select(17'h1FFFF, 16'h0000, 16'h0005);
        send_select(17'd1000, 16'd1000, 16'd7);
        send_update(8'd1, 8'd255, 8'd255, 8'd0, 8'd0, 16'd256);
        send_update(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 16'hFFFF);
        send_update(8'd2, 8'd10, 8'd3, 8'd5, 8'd40, 16'd257);
        send_update(8'd3, 8'd1, 8'd1, 8'd30, 8'd25, 16'd0);
        send_update(8'hFF, 8'd4, 8'd4, 8'd4, 8'd4, 16'd300);
        send_select(17'd0, 16'hFFFF, 16'd0);
        send_write(8'd2, 32'h7FFF_FFFF);
        send_write(8'd3, 32'h7FFF_FFFF);
        send_write(8'd1, 32'h8000_0000);
        send_write(8'(NUM_ACTIONS), 32'h1234_5678);
        send_write(8'hFF, 32'hFFFF_FFFF);
        send_select(17'd0, 16'd0, 16'd0);
        send_update(8'd2, 8'd255, 8'd255, 8'd0, 8'd0, 16'd256);
        send_update(8'd1, 8'd0, 8'd0, 8'd255, 8'd0, 16'hFFFF);
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        send_item(ACT_UNUSED, raw[ITEM_W-1:0]);
        send_write(8'd0, 32'hFFFF_FFFF);
        send_select(17'h10000, 16'h0000, 16'hAAAA);
        send_select(17'd0, 16'hFFFF, 16'h5555);
        send_write(8'd3, 32'h8000_0000);
        send_write(8'd2, 32'h8000_0000);
        send_select(17'd0, 16'd0, 16'd0);
        stop_sending();
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 1)
                set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else if (ph == 2)
                set_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            else
                set_registers(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom));
            if (ph == NUM_PHASES - 1)
                bursts_on = 1'b0;
            repeat (ITEMS_PER_PHASE) send_random_item();
            stop_sending();
            wait_idle();
        end

        $display("covered %0d selects (%0d explored), %0d updates, %0d writes, %0d unused codes",
                 sb.n_select, sb.n_explored, sb.n_update, sb.n_write, sb.n_unused);
        $display("%0d results checked over %0d register settings, %0d mismatches",
                 sb.n_checked, sb.n_settings, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("q_table_epsilon_greedy_learner_top_test: done, clean");
        else
            $display("q_table_epsilon_greedy_learner_top_test: done, errors");
        $finish;
    end

endmodule

### files.f
src/qtl_pkg.sv
src/qtl_table.sv
src/q_table_epsilon_greedy_learner_top.sv
tb/sv/q_table_epsilon_greedy_learner_top_test.sv
